// File: rtl/lattice_gas_grid_engine_macros.svh
// ----------------------------------------------------------------------------
// lattice_gas_grid_engine_macros: assertion macros for the grid engine.
// Each macro checks one implication on the rising clock edge and is
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LATTICE_GAS_GRID_ENGINE_MACROS_SVH
`define LATTICE_GAS_GRID_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LGGE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LGGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lgge_pkg.sv
// ----------------------------------------------------------------------------
// lgge_pkg: shared types and constants of the lattice-gas grid engine.
// Holds the operation codes, register indexes, word layout, direction masks,
// the HPP collision function and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lgge_pkg;

	// Field widths of the stream words and the configuration port.
	localparam int OP_W       = 2;
	localparam int COORD_W    = 6;
	localparam int CELL_W     = 8;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_INDEX_W = 1;

	// Word layout on the stream ports, lowest field first.
	localparam int OP_LSB       = 0;
	localparam int COL_LSB      = OP_LSB + OP_W;
	localparam int ROW_LSB      = COL_LSB + COORD_W;
	localparam int CELL_IN_LSB  = ROW_LSB + COORD_W;
	localparam int IN_TDATA_W   = 24;
	localparam int OUT_TDATA_W  = 16;

	// Operation codes; the fourth code touches no cell and returns an all-zero result.
	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_GEN   = 2'd2
	} op_t;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	// Reset value of both size registers.
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 7'd64;

	// Direction masks over both species of one cell.
	localparam logic [CELL_W-1:0] MASK_RIGHT = 8'h11;
	localparam logic [CELL_W-1:0] MASK_LEFT  = 8'h22;
	localparam logic [CELL_W-1:0] MASK_DOWN  = 8'h44;
	localparam logic [CELL_W-1:0] MASK_UP    = 8'h88;

	// Head-on pairs inside one species nibble.
	localparam logic [3:0] NIB_HORIZ = 4'b0011;
	localparam logic [3:0] NIB_VERT  = 4'b1100;

	// HPP collision of one species: a head-on pair turns by ninety degrees.
	function automatic logic [3:0] collide_nibble(input logic [3:0] nib);
		logic [3:0] res;
		res = nib;
		if (nib == NIB_HORIZ) begin
			res = NIB_VERT;
		end else if (nib == NIB_VERT) begin
			res = NIB_HORIZ;
		end
		return res;
	endfunction

	// Collision of both species of one cell.
	function automatic logic [CELL_W-1:0] collide_cell(input logic [CELL_W-1:0] c);
		return {collide_nibble(c[7:4]), collide_nibble(c[3:0])};
	endfunction

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;      // register the accepted input word
		logic cell_wr;      // write the addressed grid cell
		logic cell_rd;      // read the addressed grid cell
		logic sweep_rd;     // read one cell of the current sweep line
		logic sweep_flush;  // end-of-line slot of a sweep
		logic pass_b;       // vertical pass (scratch to grid)
		logic load_out;     // load the result register
		logic out_is_read;  // result carries the read cell
		logic out_status;   // result status bit
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic coord_ok;     // captured coordinate lies inside the grid in use
	} stat_t;

endpackage

// File: rtl/lgge_ctrl.sv
// ----------------------------------------------------------------------------
// lgge_ctrl: controller of the lattice-gas grid engine.
// Holds the size registers, runs the operation state machine and the sweep
// counters of a generation, and owns the handshake of both stream sides.
// ----------------------------------------------------------------------------
`include "lattice_gas_grid_engine_macros.svh"

module lgge_ctrl #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int SW = $clog2(MAX_WIDTH + 1),
	parameter int SH = $clog2(MAX_HEIGHT + 1),
	parameter int PW = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lgge_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lgge_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lgge_pkg::OP_W-1:0]           in_op,
	output logic                                out_valid,
	input  logic                                out_ready,
	input  lgge_pkg::stat_t                     stat,
	output lgge_pkg::cmd_t                      cmd,
	output logic [PW-1:0]                       pos,
	output logic [PW-1:0]                       line,
	output logic [SW-1:0]                       eff_w,
	output logic [SH-1:0]                       eff_h
);

	localparam int KW = (SW > lgge_pkg::CFG_DATA_W) ? SW : lgge_pkg::CFG_DATA_W;
	localparam int KH = (SH > lgge_pkg::CFG_DATA_W) ? SH : lgge_pkg::CFG_DATA_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_RESULT,
		ST_GEN_A,
		ST_DRAIN_A,
		ST_GEN_B,
		ST_DRAIN_B
	} state_t;

	state_t                          state_q;
	logic [lgge_pkg::OP_W-1:0]       op_q;
	logic [PW-1:0]                   pos_q;
	logic [PW-1:0]                   line_q;
	logic                            out_valid_q;
	logic [lgge_pkg::CFG_DATA_W-1:0] cfg_w_q;
	logic [lgge_pkg::CFG_DATA_W-1:0] cfg_h_q;
	logic                            in_b;
	logic [PW-1:0]                   line_len;
	logic [PW-1:0]                   line_cnt;

	// Size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= lgge_pkg::SIZE_RESET;
			cfg_h_q <= lgge_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lgge_pkg::REG_GRID_WIDTH:  cfg_w_q <= cfg_data;
				lgge_pkg::REG_GRID_HEIGHT: cfg_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sizes in use: zero acts as one, values above the maximum are clipped.
	always_comb begin
		if (cfg_w_q == '0) begin
			eff_w = SW'(1);
		end else if (KW'(cfg_w_q) > KW'(MAX_WIDTH)) begin
			eff_w = SW'(MAX_WIDTH);
		end else begin
			eff_w = SW'(cfg_w_q);
		end
		if (cfg_h_q == '0) begin
			eff_h = SH'(1);
		end else if (KH'(cfg_h_q) > KH'(MAX_HEIGHT)) begin
			eff_h = SH'(MAX_HEIGHT);
		end else begin
			eff_h = SH'(cfg_h_q);
		end
	end

	// The horizontal pass sweeps rows, the vertical pass sweeps columns.
	assign in_b     = (state_q == ST_GEN_B) || (state_q == ST_DRAIN_B);
	assign line_len = in_b ? PW'(eff_h) : PW'(eff_w);
	assign line_cnt = in_b ? PW'(eff_w) : PW'(eff_h);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign pos       = pos_q;
	assign line      = line_q;

	// Command decode.
	always_comb begin
		cmd        = '0;
		cmd.pass_b = in_b;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
			end
			ST_ACCESS: begin
				cmd.cell_wr = (op_q == lgge_pkg::OP_WRITE) && stat.coord_ok;
				cmd.cell_rd = (op_q == lgge_pkg::OP_READ) && stat.coord_ok;
			end
			ST_RESULT: begin
				cmd.load_out    = !out_valid_q || out_ready;
				cmd.out_is_read = (op_q == lgge_pkg::OP_READ);
				cmd.out_status  = ((op_q == lgge_pkg::OP_WRITE) ||
					(op_q == lgge_pkg::OP_READ)) && !stat.coord_ok;
			end
			ST_GEN_A, ST_GEN_B: begin
				cmd.sweep_rd    = (pos_q != line_len);
				cmd.sweep_flush = (pos_q == line_len);
			end
			ST_DRAIN_A, ST_DRAIN_B: ;
			default: ;
		endcase
	end

	// State machine, sweep counters and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			pos_q       <= '0;
			line_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						op_q   <= in_op;
						pos_q  <= '0;
						line_q <= '0;
						if (in_op == lgge_pkg::OP_GEN) begin
							state_q <= ST_GEN_A;
						end else begin
							state_q <= ST_ACCESS;
						end
					end
				end
				ST_ACCESS: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				ST_GEN_A, ST_GEN_B: begin
					if (pos_q == line_len) begin
						pos_q <= '0;
						if (line_q == PW'(line_cnt - 1'b1)) begin
							line_q  <= '0;
							state_q <= (state_q == ST_GEN_A) ? ST_DRAIN_A : ST_DRAIN_B;
						end else begin
							line_q <= PW'(line_q + 1'b1);
						end
					end else begin
						pos_q <= PW'(pos_q + 1'b1);
					end
				end
				ST_DRAIN_A: begin
					state_q <= ST_GEN_B;
				end
				ST_DRAIN_B: begin
					state_q <= ST_RESULT;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result is loaded only into a free or draining result register.
	`LGGE_ASSERT_SAME(a_load_when_free, clk, arst_n, cmd.load_out, !out_valid_q || out_ready, "result register overwritten")

	// Sweep counters stay inside the line and the grid in use.
	`LGGE_ASSERT_SAME(a_sweep_bound, clk, arst_n, state_q == ST_GEN_A || state_q == ST_GEN_B, pos_q <= line_len && line_q < line_cnt, "sweep counter out of range")

	// A generation starts its first pass at the first cell.
	`LGGE_ASSERT_NEXT(a_gen_start, clk, arst_n, cmd.capture && in_op == lgge_pkg::OP_GEN, state_q == ST_GEN_A && pos_q == '0 && line_q == '0, "generation did not start at origin")

endmodule

// File: rtl/lgge_datapath.sv
// ----------------------------------------------------------------------------
// lgge_datapath: memories and cell logic of the lattice-gas grid engine.
// Holds the grid and scratch memories, the captured input word, the
// three-cell window that collides and moves particles along a sweep line,
// and the result register.
// ----------------------------------------------------------------------------
`include "lattice_gas_grid_engine_macros.svh"

module lgge_datapath #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int SW = $clog2(MAX_WIDTH + 1),
	parameter int SH = $clog2(MAX_HEIGHT + 1),
	parameter int PW = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lgge_pkg::cmd_t                   cmd,
	output lgge_pkg::stat_t                  stat,
	input  logic [PW-1:0]                    pos,
	input  logic [PW-1:0]                    line,
	input  logic [SW-1:0]                    eff_w,
	input  logic [SH-1:0]                    eff_h,
	input  logic [lgge_pkg::COORD_W-1:0]     in_col,
	input  logic [lgge_pkg::COORD_W-1:0]     in_row,
	input  logic [lgge_pkg::CELL_W-1:0]      in_cell,
	output logic [lgge_pkg::CELL_W-1:0]      out_cell,
	output logic                             out_status
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int DEPTH = 2 ** (RW + CW);
	localparam int CMW   = (SW > lgge_pkg::COORD_W) ? SW : lgge_pkg::COORD_W;
	localparam int CMH   = (SH > lgge_pkg::COORD_W) ? SH : lgge_pkg::COORD_W;
	localparam logic [lgge_pkg::CELL_W-1:0] KEEP_A = lgge_pkg::MASK_DOWN | lgge_pkg::MASK_UP;
	localparam logic [lgge_pkg::CELL_W-1:0] KEEP_B = lgge_pkg::MASK_RIGHT | lgge_pkg::MASK_LEFT;

	logic [lgge_pkg::CELL_W-1:0] grid_mem [DEPTH];
	logic [lgge_pkg::CELL_W-1:0] scr_mem  [DEPTH];

	logic [lgge_pkg::COORD_W-1:0] col_q;
	logic [lgge_pkg::COORD_W-1:0] row_q;
	logic [lgge_pkg::CELL_W-1:0]  cell_in_q;
	logic [lgge_pkg::CELL_W-1:0]  grid_rdata_q;
	logic [lgge_pkg::CELL_W-1:0]  scr_rdata_q;
	logic [lgge_pkg::CELL_W-1:0]  out_cell_q;
	logic                         out_status_q;

	logic                         rd_s1;
	logic                         flush_s1;
	logic                         pass_b_s1;
	logic [PW-1:0]                pos_s1;
	logic [PW-1:0]                line_s1;

	logic                         cur_valid_q;
	logic [lgge_pkg::CELL_W-1:0]  cur_q;
	logic [lgge_pkg::CELL_W-1:0]  prev_q;
	logic [PW-1:0]                cur_pos_q;
	logic [PW-1:0]                cur_line_q;

	logic                         coord_ok;
	logic [lgge_pkg::CELL_W-1:0]  d_s1;
	logic [lgge_pkg::CELL_W-1:0]  f_d;
	logic [lgge_pkg::CELL_W-1:0]  nxt_cell;
	logic                         wb_en;
	logic [lgge_pkg::CELL_W-1:0]  wb_data;

	logic                         g_we;
	logic                         g_re;
	logic [RW+CW-1:0]             g_addr;
	logic [lgge_pkg::CELL_W-1:0]  g_wdata;
	logic                         scr_we;
	logic                         scr_re;
	logic [RW+CW-1:0]             scr_addr;

	// Captured coordinate and cell of the accepted word.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q     <= in_col;
			row_q     <= in_row;
			cell_in_q <= in_cell;
		end
	end

	// Coordinate check against the grid in use.
	assign coord_ok      = (CMW'(col_q) < CMW'(eff_w)) && (CMH'(row_q) < CMH'(eff_h));
	assign stat.coord_ok = coord_ok;

	// Sweep pipeline: a cell read from memory arrives together with its registered position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1       <= 1'b0;
			flush_s1    <= 1'b0;
			pass_b_s1   <= 1'b0;
			cur_valid_q <= 1'b0;
		end else begin
			rd_s1     <= cmd.sweep_rd;
			flush_s1  <= cmd.sweep_flush;
			pass_b_s1 <= cmd.pass_b;
			if (flush_s1) begin
				cur_valid_q <= 1'b0;
			end else if (rd_s1) begin
				cur_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s1  <= pos;
		line_s1 <= line;
		if (rd_s1) begin
			prev_q     <= cur_valid_q ? cur_q : '0;
			cur_q      <= f_d;
			cur_pos_q  <= pos_s1;
			cur_line_q <= line_s1;
		end
	end

	// Window: the horizontal pass collides and moves right and left bits,
	// the vertical pass moves down and up bits. A missing neighbor is empty.
	assign d_s1     = pass_b_s1 ? scr_rdata_q : grid_rdata_q;
	assign f_d      = pass_b_s1 ? d_s1 : lgge_pkg::collide_cell(d_s1);
	assign nxt_cell = rd_s1 ? f_d : '0;
	assign wb_en    = (rd_s1 || flush_s1) && cur_valid_q;

	always_comb begin
		if (pass_b_s1) begin
			wb_data = (cur_q & KEEP_B) | (prev_q & lgge_pkg::MASK_DOWN) |
				(nxt_cell & lgge_pkg::MASK_UP);
		end else begin
			wb_data = (cur_q & KEEP_A) | (prev_q & lgge_pkg::MASK_RIGHT) |
				(nxt_cell & lgge_pkg::MASK_LEFT);
		end
	end

	// Grid port: cell access, vertical-pass write-back, horizontal-pass read.
	always_comb begin
		g_we    = 1'b0;
		g_re    = 1'b0;
		g_wdata = cell_in_q;
		priority if (cmd.cell_wr || cmd.cell_rd) begin
			g_addr = {RW'(row_q), CW'(col_q)};
			g_we   = cmd.cell_wr;
			g_re   = cmd.cell_rd;
		end else if (wb_en && pass_b_s1) begin
			g_addr  = {RW'(cur_pos_q), CW'(cur_line_q)};
			g_we    = 1'b1;
			g_wdata = wb_data;
		end else begin
			g_addr = {RW'(line), CW'(pos)};
			g_re   = cmd.sweep_rd && !cmd.pass_b;
		end
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			grid_mem[g_addr] <= g_wdata;
		end else if (g_re) begin
			grid_rdata_q <= grid_mem[g_addr];
		end
	end

	// Scratch port: horizontal-pass write-back, vertical-pass read.
	assign scr_we   = wb_en && !pass_b_s1;
	assign scr_re   = cmd.sweep_rd && cmd.pass_b;
	assign scr_addr = scr_we ? {RW'(cur_line_q), CW'(cur_pos_q)} : {RW'(pos), CW'(line)};

	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_mem[scr_addr] <= wb_data;
		end else if (scr_re) begin
			scr_rdata_q <= scr_mem[scr_addr];
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_cell_q   <= (cmd.out_is_read && coord_ok) ? grid_rdata_q : '0;
			out_status_q <= cmd.out_status;
		end
	end

	assign out_cell   = out_cell_q;
	assign out_status = out_status_q;

	// A cell access never shares the grid port with a write-back.
	`LGGE_ASSERT_SAME(a_grid_port_free, clk, arst_n, cmd.cell_wr || cmd.cell_rd, !wb_en, "grid port conflict")

	// The scratch memory is never read and written in the same cycle.
	`LGGE_ASSERT_SAME(a_scratch_single, clk, arst_n, scr_we, !scr_re, "scratch port conflict")

	// Only a read result carries cell bits.
	`LGGE_ASSERT_NEXT(a_zero_unless_read, clk, arst_n, cmd.load_out && !cmd.out_is_read, out_cell_q == '0, "non-read result carries cell bits")

endmodule

// File: rtl/lattice_gas_grid_engine.sv
// ----------------------------------------------------------------------------
// lattice_gas_grid_engine: two-species HPP lattice-gas grid engine.
// Cell write or read: access state, then result state, then a new word may be accepted.
// Generation: a horizontal and a vertical pass, each with a drain state, then the result;
// one cell per cycle per pass plus an end-of-line slot; a stalled result adds delay.
// Reset clears control state and sets both sizes to 64; grid is undefined until written.
// ----------------------------------------------------------------------------
module lattice_gas_grid_engine #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port.
	input  logic                                  cfg_we,
	input  logic [lgge_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [lgge_pkg::CFG_DATA_W-1:0]       cfg_data,
	// Operation words.
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [lgge_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // operation, col, row, cell_in
	// Result words.
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [lgge_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // cell_out, status
);

	localparam int SW = $clog2(MAX_WIDTH + 1);
	localparam int SH = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);

	lgge_pkg::cmd_t               cmd;
	lgge_pkg::stat_t              stat;
	logic [PW-1:0]                pos;
	logic [PW-1:0]                line;
	logic [SW-1:0]                eff_w;
	logic [SH-1:0]                eff_h;
	logic [lgge_pkg::CELL_W-1:0]  out_cell;
	logic                         out_status;

	lgge_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.SW         (SW),
		.SH         (SH),
		.PW         (PW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tdata[lgge_pkg::OP_LSB +: lgge_pkg::OP_W]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd),
		.pos       (pos),
		.line      (line),
		.eff_w     (eff_w),
		.eff_h     (eff_h)
	);

	lgge_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.SW         (SW),
		.SH         (SH),
		.PW         (PW)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.pos        (pos),
		.line       (line),
		.eff_w      (eff_w),
		.eff_h      (eff_h),
		.in_col     (s_axis_tdata[lgge_pkg::COL_LSB +: lgge_pkg::COORD_W]),
		.in_row     (s_axis_tdata[lgge_pkg::ROW_LSB +: lgge_pkg::COORD_W]),
		.in_cell    (s_axis_tdata[lgge_pkg::CELL_IN_LSB +: lgge_pkg::CELL_W]),
		.out_cell   (out_cell),
		.out_status (out_status)
	);

	// Result word: cell bits, then status, zero padded to whole bytes.
	assign m_axis_tdata = {{(lgge_pkg::OUT_TDATA_W - lgge_pkg::CELL_W - 1){1'b0}},
		out_status, out_cell};

endmodule
